@@ rtl/dss_pkg.sv @@
// Shared types and constants for the damped spring stepper.
// Holds the fixed-point widths, operation codes and controller/datapath structs.
package dss_pkg;

    localparam int POS_W       = 32;
    localparam int VEL_W       = 40;
    localparam int CFG_W       = 24;
    localparam int CFG_IDX_W   = 2;
    localparam int DT_W        = 20;
    localparam int DT_FRAC     = 20;

    localparam int MAX_SUBSTEPS = 64;
    localparam int STEP_CNT_W   = $clog2(MAX_SUBSTEPS + 1);
    localparam int STEP_MUL     = 1000;
    localparam int STEP_SHIFT   = 22;
    localparam int STEP_SUM_W   = 31;
    localparam int RAW_W        = STEP_SUM_W - STEP_SHIFT;

    localparam int SUB_SHIFT   = 28;
    localparam int DT_UP       = SUB_SHIFT - DT_FRAC;
    localparam int SUB_W       = DT_W + DT_UP;
    localparam int DIV_N       = SUB_W;
    localparam int DIV_CNT_W   = $clog2(DIV_N);

    localparam int OMEGA_SHIFT = 8;
    localparam int DAMP_SHIFT  = 12;

    localparam int MAG_W       = 54;
    localparam int ACC_W       = MAG_W + 1;
    localparam int M_W         = SUB_W;
    localparam int CHUNK_W     = 32;
    localparam int PP_W        = CHUNK_W + M_W;
    localparam int PROD_W      = MAG_W + M_W;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    localparam logic [1:0] OP_SPRING = 2'd0;
    localparam logic [1:0] OP_DAMP   = 2'd1;
    localparam logic [1:0] OP_VEL    = 2'd2;
    localparam logic [1:0] OP_POS    = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_OMEGA_SQ   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DAMP_COEF  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_POS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_VEL = 2'd3;

    localparam logic [CFG_W-1:0] OMEGA_SQ_RST   = 24'd204800;
    localparam logic [CFG_W-1:0] DAMP_COEF_RST  = 24'd231711;
    localparam logic [CFG_W-1:0] SETTLE_POS_RST = 24'd32768;
    localparam logic [CFG_W-1:0] SETTLE_VEL_RST = 24'd131072;

    typedef struct packed {
        logic       latch_in;
        logic       snap;
        logic       prep;
        logic       div_step;
        logic       mul_start;
        logic [1:0] mul_op;
        logic       mul_wb;
        logic       step_inc;
        logic       out_load;
        logic       out_moving;
    } dss_cmd_t;

    typedef struct packed {
        logic is_load;
        logic omega_zero;
        logic near;
        logic exact;
        logic mul_done;
        logic step_last;
    } dss_stat_t;

endpackage

@@ rtl/damped_spring_stepper_top.sv @@
// Top level of the damped spring stepper: joins the controller and the datapath.
// Depends on dss_pkg, dss_ctrl, dss_datapath and dss_mul.
//
//   channel  handshake            payload
//   cfg      cfg_we               cfg_index, cfg_data
//   in       in_valid, in_stall   command, goal_value, time_step
//   out      out_valid, out_stall moving, new_position, new_velocity
//
// A load, a settled or near tick, or a tick with omega_sq zero skips the divider and multiplier.
// A running tick first runs a divider for the substep length, then
// four products per substep on one shared two-chunk multiplier.
// Reset clears the spring state to zero and loads the register defaults.
// One item is in work at a time; a finished beat waits in the output register.
module damped_spring_stepper_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [dss_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dss_pkg::CFG_W-1:0]        cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             command,
    input  logic signed [dss_pkg::POS_W-1:0] goal_value,
    input  logic [dss_pkg::DT_W-1:0]         time_step,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             moving,
    output logic signed [dss_pkg::POS_W-1:0] new_position,
    output logic signed [dss_pkg::VEL_W-1:0] new_velocity
);
    import dss_pkg::*;

    dss_cmd_t  cmd;
    dss_stat_t stat;

    dss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd),
        .in_stall  (in_stall),
        .out_valid (out_valid)
    );

    dss_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .command      (command),
        .goal_value   (goal_value),
        .time_step    (time_step),
        .cmd          (cmd),
        .stat         (stat),
        .moving       (moving),
        .new_position (new_position),
        .new_velocity (new_velocity)
    );

endmodule

@@ rtl/dss_mul.sv @@
// Multi-cycle unsigned multiplier for the stepper datapath.
// Splits the magnitude into two chunks and accumulates; depends on dss_pkg.
module dss_mul (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [dss_pkg::MAG_W-1:0]   a,
    input  logic [dss_pkg::M_W-1:0]     m,
    output logic                        done,
    output logic [dss_pkg::PROD_W-1:0]  prod
);
    import dss_pkg::*;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_HI   = 2'd1;
    localparam logic [1:0] PH_LO   = 2'd2;
    localparam logic [1:0] PH_SUM  = 2'd3;

    logic [1:0]        phase_reg, phase_next;
    logic              done_reg, done_next;
    logic [MAG_W-1:0]  a_reg;
    logic [M_W-1:0]    m_reg;
    logic [PP_W-1:0]   pp_reg, pp_next;
    logic [PROD_W-1:0] acc_reg, acc_next;
    logic [CHUNK_W-1:0] chunk;

    always_comb
    begin
        phase_next = phase_reg;
        done_next  = 1'b0;
        pp_next    = pp_reg;
        acc_next   = acc_reg;
        chunk      = (phase_reg == PH_HI) ? CHUNK_W'(a_reg[MAG_W-1:CHUNK_W])
                                          : a_reg[CHUNK_W-1:0];
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (start)
                begin
                    phase_next = PH_HI;
                end
            end
            PH_HI:
            begin
                pp_next    = PP_W'(chunk) * PP_W'(m_reg);
                phase_next = PH_LO;
            end
            PH_LO:
            begin
                acc_next   = PROD_W'(pp_reg);
                pp_next    = PP_W'(chunk) * PP_W'(m_reg);
                phase_next = PH_SUM;
            end
            PH_SUM:
            begin
                acc_next   = (acc_reg << CHUNK_W) + PROD_W'(pp_reg);
                done_next  = 1'b1;
                phase_next = PH_IDLE;
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && phase_reg == PH_IDLE)
        begin
            a_reg <= a;
            m_reg <= m;
        end
        pp_reg  <= pp_next;
        acc_reg <= acc_next;
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

@@ rtl/dss_datapath.sv @@
// Datapath of the stepper: configuration, spring state, divider and update logic.
// Uses dss_pkg and instantiates dss_mul; driven by commands from dss_ctrl.
module dss_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [dss_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dss_pkg::CFG_W-1:0]       cfg_data,
    input  logic                            command,
    input  logic signed [dss_pkg::POS_W-1:0] goal_value,
    input  logic [dss_pkg::DT_W-1:0]        time_step,
    input  dss_pkg::dss_cmd_t               cmd,
    output dss_pkg::dss_stat_t              stat,
    output logic                            moving,
    output logic signed [dss_pkg::POS_W-1:0] new_position,
    output logic signed [dss_pkg::VEL_W-1:0] new_velocity
);
    import dss_pkg::*;

    localparam int ERR_W = POS_W + 1;
    localparam int SUM_W = ACC_W + 1;
    localparam logic [VEL_W-1:0] VEL_MAX = {1'b0, {(VEL_W-1){1'b1}}};
    localparam logic [VEL_W-1:0] VEL_MIN = {1'b1, {(VEL_W-1){1'b0}}};
    localparam logic [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

    logic [CFG_W-1:0]      omega_reg, damp_reg, spos_reg, svel_reg;
    logic [POS_W-1:0]      pos_reg, pos_next;
    logic [VEL_W-1:0]      vel_reg, vel_next;
    logic                  cmd_reg;
    logic [POS_W-1:0]      goal_reg;
    logic [DT_W-1:0]       dt_reg;
    logic [STEP_CNT_W-1:0] steps_reg, step_cnt_reg, rem_reg;
    logic [SUB_W-1:0]      quo_reg;
    logic signed [ACC_W-1:0] t1_reg, accel_reg;
    logic                  sign_reg;
    logic                  moving_reg;
    logic [POS_W-1:0]      npos_reg;
    logic [VEL_W-1:0]      nvel_reg;

    logic [ERR_W-1:0]      err, err_abs;
    logic [VEL_W-1:0]      vel_abs;
    logic [STEP_SUM_W-1:0] step_sum;
    logic [RAW_W-1:0]      raw_steps;
    logic [STEP_CNT_W-1:0] steps_clamped;
    logic [STEP_CNT_W:0]   trial, trial_sub;
    logic                  trial_ge;
    logic [ACC_W-1:0]      opnd, opnd_neg;
    logic [MAG_W-1:0]      mag;
    logic [M_W-1:0]        mul_m;
    logic                  mul_done;
    logic [PROD_W-1:0]     prod;
    logic [MAG_W-1:0]      scaled_mag;
    logic signed [ACC_W-1:0] scaled, scaled_pos, scaled_neg;
    logic [SUM_W-1:0]      vsum, psum;
    logic [SUM_W-VEL_W:0]  vhi;
    logic [SUM_W-POS_W:0]  phi;
    logic [VEL_W-1:0]      vel_sat;
    logic [POS_W-1:0]      pos_sat;

    always_comb
    begin
        err     = {pos_reg[POS_W-1], pos_reg} - {goal_reg[POS_W-1], goal_reg};
        err_abs = err[ERR_W-1] ? -err : err;
        vel_abs = vel_reg[VEL_W-1] ? -vel_reg : vel_reg;

        step_sum  = STEP_SUM_W'(dt_reg) * STEP_SUM_W'(STEP_MUL)
                  + STEP_SUM_W'((1 << STEP_SHIFT) - 1);
        raw_steps = step_sum[STEP_SUM_W-1:STEP_SHIFT];
        if (raw_steps == '0)
        begin
            steps_clamped = STEP_CNT_W'(1);
        end
        else if (raw_steps > RAW_W'(MAX_SUBSTEPS))
        begin
            steps_clamped = STEP_CNT_W'(MAX_SUBSTEPS);
        end
        else
        begin
            steps_clamped = STEP_CNT_W'(raw_steps);
        end

        trial     = {rem_reg, quo_reg[SUB_W-1]};
        trial_sub = trial - {1'b0, steps_reg};
        trial_ge  = trial >= {1'b0, steps_reg};

        case (cmd.mul_op)
            OP_SPRING:
            begin
                opnd  = {{(ACC_W-ERR_W){err[ERR_W-1]}}, err};
                mul_m = M_W'(omega_reg);
            end
            OP_DAMP:
            begin
                opnd  = {{(ACC_W-VEL_W){vel_reg[VEL_W-1]}}, vel_reg};
                mul_m = M_W'(damp_reg);
            end
            OP_VEL:
            begin
                opnd  = accel_reg;
                mul_m = quo_reg;
            end
            default:
            begin
                opnd  = {{(ACC_W-VEL_W){vel_reg[VEL_W-1]}}, vel_reg};
                mul_m = quo_reg;
            end
        endcase
        opnd_neg = -opnd;
        mag      = opnd[ACC_W-1] ? opnd_neg[MAG_W-1:0] : opnd[MAG_W-1:0];

        case (cmd.mul_op) inside
            OP_SPRING:      scaled_mag = prod[OMEGA_SHIFT +: MAG_W];
            OP_DAMP:        scaled_mag = prod[DAMP_SHIFT +: MAG_W];
            OP_VEL, OP_POS: scaled_mag = prod[SUB_SHIFT +: MAG_W];
            default:        scaled_mag = prod[SUB_SHIFT +: MAG_W];
        endcase
        scaled_pos = $signed({1'b0, scaled_mag});
        scaled_neg = -scaled_pos;
        scaled     = sign_reg ? scaled_neg : scaled_pos;

        vsum = {{(SUM_W-VEL_W){vel_reg[VEL_W-1]}}, vel_reg} + {scaled[ACC_W-1], scaled};
        vhi  = vsum[SUM_W-1:VEL_W-1];
        if (vhi == '0 || vhi == '1)
        begin
            vel_sat = vsum[VEL_W-1:0];
        end
        else
        begin
            vel_sat = vsum[SUM_W-1] ? VEL_MIN : VEL_MAX;
        end

        psum = {{(SUM_W-POS_W){pos_reg[POS_W-1]}}, pos_reg} + {scaled[ACC_W-1], scaled};
        phi  = psum[SUM_W-1:POS_W-1];
        if (phi == '0 || phi == '1)
        begin
            pos_sat = psum[POS_W-1:0];
        end
        else
        begin
            pos_sat = psum[SUM_W-1] ? POS_MIN : POS_MAX;
        end

        pos_next = pos_reg;
        vel_next = vel_reg;
        if (cmd.snap)
        begin
            pos_next = goal_reg;
            vel_next = '0;
        end
        else if (cmd.mul_wb && cmd.mul_op == OP_VEL)
        begin
            vel_next = vel_sat;
        end
        else if (cmd.mul_wb && cmd.mul_op == OP_POS)
        begin
            pos_next = pos_sat;
        end
    end

    dss_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.mul_start),
        .a     (mag),
        .m     (mul_m),
        .done  (mul_done),
        .prod  (prod)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            omega_reg <= OMEGA_SQ_RST;
            damp_reg  <= DAMP_COEF_RST;
            spos_reg  <= SETTLE_POS_RST;
            svel_reg  <= SETTLE_VEL_RST;
            pos_reg   <= '0;
            vel_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_OMEGA_SQ:   omega_reg <= cfg_data;
                    CFG_DAMP_COEF:  damp_reg  <= cfg_data;
                    CFG_SETTLE_POS: spos_reg  <= cfg_data;
                    CFG_SETTLE_VEL: svel_reg  <= cfg_data;
                endcase
            end
            pos_reg <= pos_next;
            vel_reg <= vel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            cmd_reg  <= command;
            goal_reg <= goal_value;
            dt_reg   <= time_step;
        end
        if (cmd.prep)
        begin
            steps_reg    <= steps_clamped;
            quo_reg      <= {dt_reg, {DT_UP{1'b0}}};
            rem_reg      <= '0;
            step_cnt_reg <= '0;
        end
        else
        begin
            if (cmd.div_step)
            begin
                rem_reg <= trial_ge ? trial_sub[STEP_CNT_W-1:0] : trial[STEP_CNT_W-1:0];
                quo_reg <= {quo_reg[SUB_W-2:0], trial_ge};
            end
            if (cmd.step_inc)
            begin
                step_cnt_reg <= step_cnt_reg + 1'b1;
            end
        end
        if (cmd.mul_start)
        begin
            sign_reg <= opnd[ACC_W-1];
        end
        if (cmd.mul_wb && cmd.mul_op == OP_SPRING)
        begin
            t1_reg <= scaled;
        end
        if (cmd.mul_wb && cmd.mul_op == OP_DAMP)
        begin
            accel_reg <= -t1_reg - scaled;
        end
        if (cmd.out_load)
        begin
            moving_reg <= cmd.out_moving;
            npos_reg   <= pos_reg;
            nvel_reg   <= vel_reg;
        end
    end

    always_comb
    begin
        stat.is_load    = (cmd_reg == CMD_LOAD);
        stat.omega_zero = (omega_reg == '0);
        stat.near       = (err_abs < ERR_W'(spos_reg)) && (vel_abs < VEL_W'(svel_reg));
        stat.exact      = (pos_reg == goal_reg) && (vel_reg == '0);
        stat.mul_done   = mul_done;
        stat.step_last  = (step_cnt_reg == STEP_CNT_W'(steps_reg - 1'b1));
    end

    assign moving       = moving_reg;
    assign new_position = npos_reg;
    assign new_velocity = nvel_reg;

endmodule

@@ rtl/dss_ctrl.sv @@
// Controller state machine of the stepper: sequences decide, divide, substeps and output.
// Uses dss_pkg for the command and status structs.
module dss_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               out_stall,
    input  dss_pkg::dss_stat_t stat,
    output dss_pkg::dss_cmd_t  cmd,
    output logic               in_stall,
    output logic               out_valid
);
    import dss_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DECIDE = 3'd1;
    localparam logic [2:0] ST_DIV    = 3'd2;
    localparam logic [2:0] ST_MUL    = 3'd3;
    localparam logic [2:0] ST_WAIT   = 3'd4;
    localparam logic [2:0] ST_CHECK  = 3'd5;
    localparam logic [2:0] ST_FINISH = 3'd6;

    logic [2:0]           state_reg, state_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic [1:0]           op_reg, op_next;
    logic                 moving_reg, moving_next;
    logic                 out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next   = state_reg;
        div_cnt_next = div_cnt_reg;
        op_next      = op_reg;
        moving_next  = moving_reg;
        cmd            = '0;
        cmd.mul_op     = op_reg;
        cmd.out_moving = moving_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch_in = 1'b1;
                    state_next   = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (stat.is_load)
                begin
                    cmd.snap    = 1'b1;
                    moving_next = 1'b0;
                    state_next  = ST_FINISH;
                end
                else if (stat.omega_zero)
                begin
                    moving_next = 1'b0;
                    state_next  = ST_FINISH;
                end
                else if (stat.near)
                begin
                    cmd.snap    = 1'b1;
                    moving_next = !stat.exact;
                    state_next  = ST_FINISH;
                end
                else
                begin
                    cmd.prep     = 1'b1;
                    moving_next  = 1'b1;
                    div_cnt_next = '0;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (div_cnt_reg == DIV_CNT_W'(DIV_N - 1))
                begin
                    op_next    = OP_SPRING;
                    state_next = ST_MUL;
                end
                else
                begin
                    div_cnt_next = div_cnt_reg + 1'b1;
                end
            end
            ST_MUL:
            begin
                cmd.mul_start = 1'b1;
                state_next    = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (stat.mul_done)
                begin
                    cmd.mul_wb = 1'b1;
                    if (op_reg == OP_POS)
                    begin
                        cmd.step_inc = 1'b1;
                        op_next      = OP_SPRING;
                        state_next   = stat.step_last ? ST_CHECK : ST_MUL;
                    end
                    else
                    begin
                        op_next    = op_reg + 1'b1;
                        state_next = ST_MUL;
                    end
                end
            end
            ST_CHECK:
            begin
                cmd.snap   = stat.near;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            div_cnt_reg   <= '0;
            op_reg        <= OP_SPRING;
            moving_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            div_cnt_reg   <= div_cnt_next;
            op_reg        <= op_next;
            moving_reg    <= moving_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule
